// File: rtl/ccm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccm_pkg
// Shared types for the cyclic convolution block: the control word that the
// sequencer sends along the row of cells, and the sequencer state.
// ----------------------------------------------------------------------------
package ccm_pkg;

   // Control shared by every cell of the row in one cycle.
   typedef struct packed {
      logic clr;     // clear the accumulator
      logic mac;     // accumulate a * broadcast b, then rotate both stores
      logic shift;   // move accumulators one cell toward the output
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_CALC = 3'b010,
      ST_SEND = 3'b100
   } state_type;

endpackage

// File: rtl/cyclic_convolution_24_mod_4096.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyclic_convolution_24_mod_4096
// Cyclic product of two polynomials modulo x^POLY_LEN - 1, coefficients kept
// modulo 2^COEF_BITS, computed in a row of multiply-accumulate cells.
// ----------------------------------------------------------------------------
// Items are taken back to back while the block is loading. After the item
// marked last the row makes one rotation step of the a and b stores per
// cycle until both stores have made a full turn, then it sends POLY_LEN
// results, one per cycle when the output is not stalled.
// Input is stalled from the last item until the last result is taken.
// Reset clears the sequencer only; the coefficient stores are not cleared.
// ----------------------------------------------------------------------------
module cyclic_convolution_24_mod_4096 #(
   parameter int POLY_LEN  = 24,
   parameter int COEF_BITS = 12,
   parameter int IDX_W     = $clog2(POLY_LEN)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [IDX_W-1:0]     req_coef_index,
   input  logic [COEF_BITS-1:0] req_a_coef,
   input  logic [COEF_BITS-1:0] req_b_coef,
   input  logic                 req_last_coef,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [IDX_W-1:0]     rsp_result_index,
   output logic [COEF_BITS-1:0] rsp_result_coef,
   output logic                 rsp_last_result
);

   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(POLY_LEN - 1);

   ccm_pkg::state_type    state_ff, state_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   ccm_pkg::cell_ctl_type ctl;
   logic                  req_acc, rsp_acc;

   logic [COEF_BITS-1:0]  a_q   [POLY_LEN];
   logic [COEF_BITS-1:0]  b_q   [POLY_LEN];
   logic [COEF_BITS-1:0]  acc_q [POLY_LEN];

   assign req_stall = (state_ff != ccm_pkg::ST_LOAD);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ccm_pkg::ST_SEND);
   assign rsp_acc   = rsp_valid && !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ctl.clr   = 1'b0;
      ctl.mac   = 1'b0;
      ctl.shift = 1'b0;
      case (state_ff)
         ccm_pkg::ST_LOAD: begin
            if (req_acc && req_last_coef) begin
               ctl.clr  = 1'b1;
               cnt_in   = '0;
               state_in = ccm_pkg::ST_CALC;
            end
         end
         ccm_pkg::ST_CALC: begin
            ctl.mac = 1'b1;
            if (cnt_ff == LAST_POS) begin
               cnt_in   = '0;
               state_in = ccm_pkg::ST_SEND;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ccm_pkg::ST_SEND: begin
            if (rsp_acc) begin
               ctl.shift = 1'b1;
               if (cnt_ff == LAST_POS) begin
                  cnt_in   = '0;
                  state_in = ccm_pkg::ST_LOAD;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ccm_pkg::ST_LOAD;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ccm_pkg::ST_LOAD;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Cell k sees a rotating toward higher positions and b toward cell 0, so
   // in step j cell k multiplies a[(k - j) mod POLY_LEN] by b[j].
   for (genvar k = 0; k < POLY_LEN; k++) begin : g_cell
      localparam int PREV = (k + POLY_LEN - 1) % POLY_LEN;
      localparam int NEXT = (k + 1) % POLY_LEN;
      logic                 wr_en;
      logic [COEF_BITS-1:0] acc_right;

      assign wr_en     = req_acc && (req_coef_index == IDX_W'(k));
      assign acc_right = (k == POLY_LEN - 1) ? '0 : acc_q[NEXT];

      ccm_cell #(
         .COEF_BITS (COEF_BITS)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .wr_en     (wr_en),
         .a_wr      (req_a_coef),
         .b_wr      (req_b_coef),
         .a_left    (a_q[PREV]),
         .b_right   (b_q[NEXT]),
         .b_bcast   (b_q[0]),
         .acc_right (acc_right),
         .a_q       (a_q[k]),
         .b_q       (b_q[k]),
         .acc_q     (acc_q[k])
      );
   end

   assign rsp_result_index = cnt_ff;
   assign rsp_result_coef  = acc_q[0];
   assign rsp_last_result  = (cnt_ff == LAST_POS);

   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while results are pending");

   a_last_starts_calc: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_last_coef) |=> (state_ff == ccm_pkg::ST_CALC && cnt_ff == '0))
      else $error("last item did not start the product");

   a_calc_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ccm_pkg::ST_CALC && cnt_ff != LAST_POS)
      |=> (state_ff == ccm_pkg::ST_CALC && cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("product step count broken");

   a_send_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_last_result) |=> (state_ff == ccm_pkg::ST_LOAD))
      else $error("block not idle after final result");

   a_send_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(cnt_ff)))
      else $error("stalled result position moved");

endmodule

// File: rtl/ccm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccm_cell
// One cell of the convolution row: holds one a and one b coefficient and one
// product accumulator, and hands each of them to a neighbor.
// ----------------------------------------------------------------------------
module ccm_cell #(
   parameter int COEF_BITS = 12
) (
   input  logic                   clock,
   input  ccm_pkg::cell_ctl_type  ctl,
   input  logic                   wr_en,
   input  logic [COEF_BITS-1:0]   a_wr,
   input  logic [COEF_BITS-1:0]   b_wr,
   input  logic [COEF_BITS-1:0]   a_left,
   input  logic [COEF_BITS-1:0]   b_right,
   input  logic [COEF_BITS-1:0]   b_bcast,
   input  logic [COEF_BITS-1:0]   acc_right,
   output logic [COEF_BITS-1:0]   a_q,
   output logic [COEF_BITS-1:0]   b_q,
   output logic [COEF_BITS-1:0]   acc_q
);

   logic [COEF_BITS-1:0]   a_ff, a_in;
   logic [COEF_BITS-1:0]   b_ff, b_in;
   logic [COEF_BITS-1:0]   acc_ff, acc_in;
   logic [COEF_BITS-1:0]   prod;

   // Only the low bits of the product reach the modular sum.
   assign prod = a_ff * b_bcast;

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      acc_in = acc_ff;
      if (wr_en) begin
         a_in = a_wr;
         b_in = b_wr;
      end else if (ctl.mac) begin
         // After a full turn of the row both stores are back in place.
         a_in = a_left;
         b_in = b_right;
      end
      if (ctl.clr) begin
         acc_in = '0;
      end else if (ctl.mac) begin
         acc_in = acc_ff + prod;
      end else if (ctl.shift) begin
         acc_in = acc_right;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign a_q   = a_ff;
   assign b_q   = b_ff;
   assign acc_q = acc_ff;

endmodule
